/* hdl/greedy_word_wrap_line_breaker_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the greedy word wrap line breaker
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_TOP_MACROS_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define GWWL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define GWWL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GWWL_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define GWWL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hdl/gwwl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwl_pkg
// Shared types and constants of the greedy word wrap line breaker.
// ----------------------------------------------------------------------------
package gwwl_pkg;

  localparam logic [7:0]  END_CODE = 8'd0;
  localparam logic [7:0]  SEP_CODE = 8'd32;

  localparam int          LINE_LIMIT_DEFAULT = 32;
  localparam int          QUEUE_DEPTH_DEFAULT = 4;

  // Register indexes on the configuration channel
  localparam logic [1:0]  REG_MAX_WIDTH    = 2'd0;
  localparam logic [1:0]  REG_CHAR_SPACING = 2'd1;
  localparam logic [1:0]  REG_SPACE_WIDTH  = 2'd2;

  localparam logic [15:0] MAX_WIDTH_RST    = 16'd640;
  localparam logic [3:0]  CHAR_SPACING_RST = 4'd0;
  localparam logic [7:0]  SPACE_WIDTH_RST  = 8'd8;

  typedef struct packed {
    logic [15:0]        max_width;
    logic signed [3:0]  char_spacing;
    logic [7:0]         space_width;
  } gwwl_cfg_t;

  // One finished word as handed from front to back
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] length;
    logic        is_end;
  } gwwl_word_t;

  typedef struct packed {
    logic        overflow;
    logic        last_line;
    logic [15:0] line_length;
    logic [15:0] line_width;
    logic [4:0]  line_number;
  } gwwl_res_t;

  function automatic logic [15:0] spacing_ext(input logic signed [3:0] sp);
    return {{12{sp[3]}}, sp};
  endfunction

endpackage

/* hdl/gwwl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwl_front
// Accumulate glyph widths of the open word; push the word on a break code.
// ----------------------------------------------------------------------------
module gwwl_front
  import gwwl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        char_code,
  input  logic [7:0]        glyph_width,
  input  logic signed [3:0] char_spacing,
  output logic              push,
  output gwwl_word_t        push_word
);

  logic [15:0] word_width_acc;
  logic [15:0] word_length_acc;
  logic [15:0] sp16;
  logic        is_break;

  assign sp16     = spacing_ext(char_spacing);
  assign is_break = (char_code == END_CODE) || (char_code == SEP_CODE);

  assign push              = in_fire && is_break;
  assign push_word.width   = 16'(word_width_acc - sp16);
  assign push_word.length  = word_length_acc;
  assign push_word.is_end  = (char_code == END_CODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_width_acc  <= '0;
      word_length_acc <= '0;
    end else if (in_fire) begin
      if (is_break) begin
        word_width_acc  <= '0;
        word_length_acc <= '0;
      end else begin
        word_width_acc  <= 16'(word_width_acc + {8'd0, glyph_width} + sp16);
        word_length_acc <= 16'(word_length_acc + 16'd1);
      end
    end
  end

endmodule

/* hdl/gwwl_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwwl_fifo
// Short word queue between front and back.
// ----------------------------------------------------------------------------
module gwwl_fifo
  import gwwl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  gwwl_word_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output logic       rd_valid,
  output gwwl_word_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  gwwl_word_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= CW'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

/* hdl/gwwl_back.sv */
`timescale 1ns / 1ps
`include "greedy_word_wrap_line_breaker_top_macros.svh"
// ----------------------------------------------------------------------------
// gwwl_back
// Place words on lines and drive the result register.
// ----------------------------------------------------------------------------
module gwwl_back
  import gwwl_pkg::*;
#(
  parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
)(
  input  logic       clk,
  input  logic       rst,
  input  gwwl_cfg_t  cfg,
  input  logic       word_valid,
  input  gwwl_word_t word,
  output logic       word_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output gwwl_res_t  out_res
);

  localparam int IDX_CAP_I = (LINE_LIMIT - 1 > 31) ? 31 : LINE_LIMIT - 1;
  localparam logic [4:0] IDX_CAP = 5'(IDX_CAP_I);

  logic [15:0] line_width_acc;
  logic [15:0] line_length_acc;
  logic        first_word_flag;
  logic [4:0]  line_index;
  logic        overflow_seen;

  logic        pend_valid;
  gwwl_res_t   pend_res;

  logic        slot_free;
  logic [15:0] sp16;
  logic [15:0] join_cost;
  logic [15:0] need;
  logic [16:0] fit_sum;
  logic        fits;
  logic        spill;
  logic [15:0] nl_width;
  logic [15:0] nl_length;
  logic [4:0]  n_index;
  logic        n_ovf;
  gwwl_res_t   spill_res;
  gwwl_res_t   final_res;

  assign slot_free = !out_valid || out_ready;
  assign word_pop  = word_valid && slot_free && !pend_valid;

  assign sp16      = spacing_ext(cfg.char_spacing);
  assign join_cost = 16'({8'd0, cfg.space_width} + sp16 + sp16);
  assign need      = 16'(join_cost + word.width);
  assign fit_sum   = {1'b0, line_width_acc} + {1'b0, need};
  assign fits      = (fit_sum <= {1'b0, cfg.max_width});
  assign spill     = !first_word_flag && !fits;

  always_comb begin
    n_index = line_index;
    n_ovf   = overflow_seen;
    if (first_word_flag || spill) begin
      nl_width  = word.width;
      nl_length = word.length;
    end else begin
      nl_width  = 16'(line_width_acc + need);
      nl_length = 16'(line_length_acc + 16'd1 + word.length);
    end
    if (spill) begin
      if (line_index >= IDX_CAP) begin
        n_ovf = 1'b1;
      end else begin
        n_index = 5'(line_index + 1'b1);
      end
    end
  end

  always_comb begin
    spill_res.line_number = line_index;
    spill_res.line_width  = line_width_acc;
    spill_res.line_length = line_length_acc;
    spill_res.last_line   = 1'b0;
    spill_res.overflow    = overflow_seen;
    final_res.line_number = n_index;
    final_res.line_width  = nl_width;
    final_res.line_length = nl_length;
    final_res.last_line   = 1'b1;
    final_res.overflow    = n_ovf;
  end

  // Sentence state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width_acc  <= '0;
      line_length_acc <= '0;
      first_word_flag <= 1'b1;
      line_index      <= '0;
      overflow_seen   <= 1'b0;
    end else if (word_pop) begin
      if (word.is_end) begin
        line_width_acc  <= '0;
        line_length_acc <= '0;
        first_word_flag <= 1'b1;
        line_index      <= '0;
        overflow_seen   <= 1'b0;
      end else begin
        line_width_acc  <= nl_width;
        line_length_acc <= nl_length;
        first_word_flag <= 1'b0;
        line_index      <= n_index;
        overflow_seen   <= n_ovf;
      end
    end
  end

  // Result register and the held final line after a spill at sentence end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid) begin
        if (slot_free) begin
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end
      end else if (word_pop) begin
        out_valid  <= spill || word.is_end;
        pend_valid <= spill && word.is_end;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid) begin
      if (slot_free) begin
        out_res <= pend_res;
      end
    end else if (word_pop) begin
      out_res  <= spill ? spill_res : final_res;
      pend_res <= final_res;
    end
  end

  `GWWL_ASSERT_IMPL(a_no_pop_while_pending, clk, rst, pend_valid, !word_pop,
                    "word taken while a final line is pending")
  `GWWL_ASSERT_IMPL(a_index_capped, clk, rst, 1'b1, line_index <= IDX_CAP,
                    "line index above cap")
  `GWWL_ASSERT_NEXT(a_end_restarts, clk, rst, word_pop && word.is_end,
                    first_word_flag && !overflow_seen && line_index == '0,
                    "sentence state not cleared after end")
  `GWWL_ASSERT_NEXT(a_pending_follows_spill, clk, rst,
                    word_pop && spill && word.is_end,
                    pend_valid && out_valid && !out_res.last_line,
                    "spilled line and final line out of order")

endmodule

/* hdl/greedy_word_wrap_line_breaker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker_top
// Greedy word wrap of a character stream into lines of limited pixel width.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per transaction: code in tdata[7:0], glyph
//   width in tdata[15:8]. Code 32 separates words, code 0 ends the sentence.
//   m_axis carries one finished line per transaction; tlast marks the final
//   line of a sentence and tuser raises when the line limit was exceeded.
//   The cfg channel writes max_width (0), char_spacing (1), space_width (2);
//   it is always ready and must only be used while the block is idle.
// Timing:
//   One character is taken every cycle while the queue has room. Word breaks
//   go through a short queue to the line stage, which registers each line and
//   places one word per cycle unless m_axis stalls or a final line is held. A
//   sentence end that also spills gives two lines, the spilled one first.
// Reset (rst, synchronous): registers return to 640 / 0 / 8, the open word
//   and line are dropped and the line count restarts at zero.
// Stall: a held m_axis keeps its line stable; the line stage and then the
//   queue fill, after which s_axis_tready drops until room frees up.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker_top
  import gwwl_pkg::*;
#(
  parameter int LINE_LIMIT  = LINE_LIMIT_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
  input  logic        clk,
  input  logic        rst,
  // Character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] char_code, [15:8] glyph_width
  // Line stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] line_number, [20:5] line_width,
                                      // [36:21] line_length, [39:37] zero
  output logic        m_axis_tlast,   // last_line
  output logic        m_axis_tuser,   // [0] overflow
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  gwwl_cfg_t  cfg;
  logic       in_fire;
  logic       push;
  gwwl_word_t push_word;
  logic       queue_full;
  logic       word_valid;
  gwwl_word_t word;
  logic       word_pop;
  gwwl_res_t  res;

  // Register file: always ready, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_width    <= MAX_WIDTH_RST;
      cfg.char_spacing <= CHAR_SPACING_RST;
      cfg.space_width  <= SPACE_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_WIDTH:    cfg.max_width    <= cfg_data;
        REG_CHAR_SPACING: cfg.char_spacing <= cfg_data[3:0];
        REG_SPACE_WIDTH:  cfg.space_width  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Hold off input only when the word queue has no room
  assign s_axis_tready = !queue_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  gwwl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .char_code    (s_axis_tdata[7:0]),
    .glyph_width  (s_axis_tdata[15:8]),
    .char_spacing (cfg.char_spacing),
    .push         (push),
    .push_word    (push_word)
  );

  gwwl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (push_word),
    .full     (queue_full),
    .rd_en    (word_pop),
    .rd_valid (word_valid),
    .rd_data  (word)
  );

  gwwl_back #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .word_valid (word_valid),
    .word       (word),
    .word_pop   (word_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (res)
  );

  // Pack the line result onto the output bus
  assign m_axis_tdata = {3'b000, res.line_length, res.line_width, res.line_number};
  assign m_axis_tlast = res.last_line;
  assign m_axis_tuser = res.overflow;

endmodule

/* bench/greedy_word_wrap_line_breaker_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker_top_tb
// Self-checking bench for the greedy word wrap line breaker.
// Characters stream in on s_axis, and a line predictor in the bench works out
// each finished line. Lines from m_axis are compared field by field against
// that prediction, in order. The run covers a short directed set and then
// random sentences under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker_top_tb;
  import gwwl_pkg::*;

  localparam int TB_LINE_LIMIT = LINE_LIMIT_DEFAULT;
  localparam int LINE_CAP      = (TB_LINE_LIMIT - 1 > 31) ? 31 : TB_LINE_LIMIT - 1;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 145;
  localparam int NUM_PHASES    = 8;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] code;
  } char_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  greedy_word_wrap_line_breaker_top #(
    .LINE_LIMIT(TB_LINE_LIMIT)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pending characters and the lines they are predicted to produce
  char_item_t char_q[$];
  gwwl_res_t  line_exp_q[$];

  // Idle pattern of the current phase, in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-off request and its countdown
  logic pressure_go   = 1'b0;
  logic pressure_done = 1'b0;
  int   rx_hold_left  = 0;

  logic char_taken = 1'b0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   chars_sent = 0;
  int   lines_checked = 0;
  int   last_lines = 0;
  int   overflow_lines = 0;
  int   queued_items = 0;

  // Line predictor: register copies and sentence state
  logic [15:0]       cfg_max_w   = MAX_WIDTH_RST;
  logic signed [3:0] cfg_sp      = CHAR_SPACING_RST;
  logic [7:0]        cfg_space_w = SPACE_WIDTH_RST;

  logic [15:0] open_line_width = '0;
  logic [15:0] open_line_chars = '0;
  logic [15:0] open_word_width = '0;
  logic [15:0] open_word_chars = '0;
  logic        at_line_start   = 1'b1;
  logic [4:0]  cur_line_no     = '0;
  logic        lines_capped    = 1'b0;

  function automatic void close_line(logic is_last);
    gwwl_res_t r;
    r.line_number = cur_line_no;
    r.line_width  = open_line_width;
    r.line_length = open_line_chars;
    r.last_line   = is_last;
    r.overflow    = lines_capped;
    line_exp_q.push_back(r);
  endfunction

  // Advance the line state by one character and queue any finished lines
  function automatic void wrap_char(logic [7:0] code, logic [7:0] glyph);
    logic [15:0] sp16;
    logic [15:0] word_w;
    logic [15:0] word_n;
    logic [15:0] need;
    sp16 = 16'(cfg_sp);
    if (code != END_CODE && code != SEP_CODE) begin
      open_word_width = open_word_width + 16'(glyph) + sp16;
      open_word_chars = open_word_chars + 16'd1;
      return;
    end
    // Drop the spacing after the word's final character
    word_w = open_word_width - sp16;
    word_n = open_word_chars;
    open_word_width = '0;
    open_word_chars = '0;
    if (at_line_start) begin
      open_line_width = word_w;
      open_line_chars = word_n;
      at_line_start   = 1'b0;
    end else begin
      need = 16'(cfg_space_w) + sp16 + sp16 + word_w;
      // Fit test in 17 bits, no wrap
      if (17'(open_line_width) + 17'(need) <= 17'(cfg_max_w)) begin
        open_line_width = open_line_width + need;
        open_line_chars = open_line_chars + 16'd1 + word_n;
      end else begin
        close_line(1'b0);
        if (cur_line_no >= LINE_CAP) lines_capped = 1'b1;
        else cur_line_no = cur_line_no + 5'd1;
        open_line_width = word_w;
        open_line_chars = word_n;
      end
    end
    if (code == END_CODE) begin
      close_line(1'b1);
      open_line_width = '0;
      open_line_chars = '0;
      at_line_start   = 1'b1;
      cur_line_no     = '0;
      lines_capped    = 1'b0;
    end
  endfunction

  function automatic void check_line();
    gwwl_res_t got;
    gwwl_res_t want;
    got.line_number = m_axis_tdata[4:0];
    got.line_width  = m_axis_tdata[20:5];
    got.line_length = m_axis_tdata[36:21];
    got.last_line   = m_axis_tlast;
    got.overflow    = m_axis_tuser;
    lines_checked++;
    if (got.last_line) last_lines++;
    if (got.overflow) overflow_lines++;
    if (line_exp_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected line: num=%0d width=%0d len=%0d last=%0b ovf=%0b",
                 got.line_number, got.line_width, got.line_length,
                 got.last_line, got.overflow);
      return;
    end
    want = line_exp_q.pop_front();
    if (got.line_number != want.line_number || got.line_width != want.line_width ||
        got.line_length != want.line_length || got.last_line != want.last_line ||
        got.overflow != want.overflow) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: want %0d %0d %0d %0b %0b, got %0d %0d %0d %0b %0b",
                 want.line_number, want.line_width, want.line_length,
                 want.last_line, want.overflow,
                 got.line_number, got.line_width, got.line_length,
                 got.last_line, got.overflow);
    end
  endfunction

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    char_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_line();
      if (s_axis_tvalid && s_axis_tready) begin
        wrap_char(s_axis_tdata[7:0], s_axis_tdata[15:8]);
        chars_sent++;
      end
    end
  end

  // Character driver: hold an offered transaction until taken, then advance
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || char_taken) begin
      if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata  <= char_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Line receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      pressure_done <= 1'b1;
      rx_hold_left  <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lines outstanding", cycle_count,
               line_exp_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_char(logic [7:0] code, logic [7:0] glyph);
    char_item_t it;
    it.code  = code;
    it.glyph = glyph;
    char_q.push_back(it);
    queued_items++;
  endtask

  // Any word character: codes 1..255 except the separator
  function automatic logic [7:0] rand_letter();
    int c;
    c = $urandom_range(1, 254);
    if (c >= SEP_CODE) c++;
    return 8'(c);
  endfunction

  function automatic logic [7:0] rand_glyph();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 24));
  endfunction

  task automatic queue_sentence(int max_words);
    int n_words;
    int n_chars;
    n_words = $urandom_range(1, max_words);
    for (int w = 0; w < n_words; w++) begin
      n_chars = $urandom_range(0, 6);
      for (int c = 0; c < n_chars; c++) queue_char(rand_letter(), rand_glyph());
      if (w != n_words - 1) queue_char(SEP_CODE, 8'($urandom_range(0, 255)));
    end
    queue_char(END_CODE, 8'($urandom_range(0, 255)));
  endtask

  // Wait until every character is taken and every line is back, then settle
  task automatic drain();
    while (char_q.size() != 0 || s_axis_tvalid || line_exp_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_WIDTH:    cfg_max_w   = value;
      REG_CHAR_SPACING: cfg_sp      = value[3:0];
      REG_SPACE_WIDTH:  cfg_space_w = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] max_w, logic [3:0] sp, logic [7:0] space_w);
    write_reg(REG_MAX_WIDTH, max_w);
    write_reg(REG_CHAR_SPACING, {12'd0, sp});
    write_reg(REG_SPACE_WIDTH, {8'd0, space_w});
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int mode;
    int phase_start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty sentence, empty words, field extremes, oversized word,
    // spill on the final word, all under reset register values
    queue_char(END_CODE, 8'hFF);
    queue_char(SEP_CODE, 8'h00);
    queue_char(END_CODE, 8'h00);
    queue_char(8'hFF, 8'hFF);
    queue_char(8'h01, 8'h00);
    queue_char(SEP_CODE, 8'hAA);
    queue_char(SEP_CODE, 8'h55);
    queue_char(8'h7F, 8'h80);
    queue_char(END_CODE, 8'h00);
    queue_char(8'h41, 8'd10);
    queue_char(SEP_CODE, 8'd0);
    queue_char(8'h80, 8'd255);
    queue_char(8'h42, 8'd255);
    queue_char(8'h43, 8'd255);
    queue_char(SEP_CODE, 8'd0);
    queue_char(8'h44, 8'd200);
    queue_char(8'h45, 8'd200);
    queue_char(SEP_CODE, 8'd0);
    queue_char(8'h46, 8'd250);
    queue_char(8'h47, 8'd250);
    queue_char(END_CODE, 8'd0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_regs(16'd640, 4'd0, 8'd8);
        1: load_regs(16'd65535, 4'd7, 8'd255);
        2: load_regs(16'd0, 4'h8, 8'd0);        // spacing -8, join cost wraps
        3: load_regs(16'd60, 4'hD, 8'd4);
        4: load_regs(16'd100, 4'd2, 8'd10);
        default: load_regs(($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 400))
                                                        : 16'($urandom),
                           4'($urandom), 8'($urandom));
      endcase
      // Rotate: no idling, sender idle, receiver stall, both
      mode = (p + 1) % 4;
      send_idle_pct  = (mode == 1) ? 56 : (mode == 3) ? 14 : 0;
      recv_stall_pct = (mode == 2) ? 56 : (mode == 3) ? 14 : 0;
      if (p == 4) begin
        // Long receiver hold-off while characters keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go   <= 1'b1;
      end
      phase_start = queued_items;
      while (queued_items - phase_start < PHASE_ITEMS) begin
        // Some noise: arbitrary codes, terminators and separators included
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 4))
            queue_char(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_sentence(($urandom_range(0, 5) == 0) ? 40 : 8);
      end
      // Wide spacing: one long word wraps its width past 16 bits
      if (p == 1) begin
        repeat (300) queue_char(rand_letter(), 8'd255);
        queue_char(END_CODE, 8'd0);
      end
      drain();
    end

    mismatches += line_exp_q.size();
    $display("covered %0d characters in %0d register settings, %0d lines checked",
             chars_sent, NUM_PHASES + 1, lines_checked);
    $display("%0d sentence ends, %0d lines with overflow, %0d mismatches",
             last_lines, overflow_lines, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/gwwl_pkg.sv
hdl/gwwl_front.sv
hdl/gwwl_fifo.sv
hdl/gwwl_back.sv
hdl/greedy_word_wrap_line_breaker_top.sv
bench/greedy_word_wrap_line_breaker_top_tb.sv
